/* sv/cv3_pkg.sv */
// Package for the 3x3 valid-region convolution stream.
// Holds fixed-point formats, register indexes and reset values.
// No dependencies.
package cv3_pkg;

  // Default sizes for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  // Kernel and fixed-point formats
  localparam int KSIZE      = 3;
  localparam int COEF_BITS  = 16;       // Q4.12
  localparam int FRAC_DROP  = 12;       // Q.20 products down to Q.8
  localparam int ROUND_BIAS = 1 << (FRAC_DROP - 1);
  localparam int OUT_BITS   = 24;       // Q16.8
  localparam int OUT_MAX    = 8388607;
  localparam int OUT_MIN    = -8388608;

  // Config port and register widths
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = KSIZE * COEF_BITS;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 16;
  localparam int PCOUNT_BITS    = 3;
  localparam int PLANE_BITS     = 2;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  // Register indexes
  localparam cfg_index_t REG_COEF_ROW0    = 3'd0;
  localparam cfg_index_t REG_COEF_ROW1    = 3'd1;
  localparam cfg_index_t REG_COEF_ROW2    = 3'd2;
  localparam cfg_index_t REG_IMAGE_WIDTH  = 3'd3;
  localparam cfg_index_t REG_IMAGE_HEIGHT = 3'd4;
  localparam cfg_index_t REG_PLANE_COUNT  = 3'd5;

  // Reset values: identity kernel, 1024x1024, three planes
  localparam logic [CFG_DATA_BITS-1:0] RST_COEF_ROW0 = 48'h0000_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_COEF_ROW1 = 48'h0000_1000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_COEF_ROW2 = 48'h0000_0000_0000;
  localparam logic [WIDTH_BITS-1:0]    RST_WIDTH     = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0]   RST_HEIGHT    = 16'd1024;
  localparam logic [PCOUNT_BITS-1:0]   RST_PCOUNT    = 3'd3;

endpackage

/* sv/cv3_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the line store. No dependencies.
module cv3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/conv3x3_valid_stream.sv */
// Streaming 3x3 valid-region correlation over raster-order pixel planes.
//
// Channels: pixel (valid/ready) carries one signed Q8.8 sample per transfer,
// raster order within a plane, planes back to back. result (valid/ready)
// carries one Q16.8 sum per window whose row and column are both >= 2, plus
// last_in_plane / last_in_image flags. cfg (valid/ready, always ready)
// writes one register per transfer: coef_row0..2, image_width, image_height,
// plane_count; write only while no pixel is in flight.
//
// Each result passes the stage-one register (line-store read), the product
// register, the sum register and the output register.
// Throughput: one pixel per cycle while result_ready stays high; the line
// store read and write each use one RAM port per pixel.
// When the receiver stalls, the pipeline fills and bubbles collapse;
// pixel_ready drops only once every stage holding a result is occupied.
// Pixels that produce no result keep flowing as long as stage one can drain.
// Reset clears counters, pipeline valids and config registers (identity
// kernel, 1024x1024, three planes). The line store is not cleared; no
// result reads an entry before it has been written in the current plane.
// Depends on cv3_pkg and cv3_ram.
module conv3x3_valid_stream #(
  parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = cv3_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  logic signed [PIXEL_BITS-1:0]        pixel,
  // result output
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [cv3_pkg::OUT_BITS-1:0] out_value,
  output logic                                last_in_plane,
  output logic                                last_in_image,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  cv3_pkg::cfg_index_t                 cfg_index,
  input  logic [cv3_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int PROD_W = PIXEL_BITS + cv3_pkg::COEF_BITS;
  localparam int SUM_W  = PROD_W + 4;
  localparam int WIDE_W = SUM_W + 1 + cv3_pkg::OUT_BITS;
  localparam int K      = cv3_pkg::KSIZE;
  localparam int CB     = cv3_pkg::COEF_BITS;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(cv3_pkg::OUT_MAX);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = WIDE_W'(cv3_pkg::OUT_MIN);

  // Config registers
  logic [cv3_pkg::CFG_DATA_BITS-1:0] coef_row [K];
  logic [cv3_pkg::WIDTH_BITS-1:0]    image_width;
  logic [cv3_pkg::HEIGHT_BITS-1:0]   image_height;
  logic [cv3_pkg::PCOUNT_BITS-1:0]   plane_count;

  // Position counters
  logic [COL_W-1:0]                  column_count;
  logic [cv3_pkg::HEIGHT_BITS-1:0]   row_count;
  logic [cv3_pkg::PLANE_BITS-1:0]    plane_index;

  // Effective limits
  logic [COL_W-1:0]                  w_last;
  logic [cv3_pkg::HEIGHT_BITS-1:0]   h_last;
  logic [cv3_pkg::PLANE_BITS-1:0]    pc_last;
  logic                              row_end, plane_end, image_end, emit;

  // Stage 1: pixel plus line-store read
  logic                              s1_valid;
  logic signed [PIXEL_BITS-1:0]      s1_pixel;
  logic [COL_W-1:0]                  s1_col;
  logic                              s1_emit, s1_plane_end, s1_image_end;
  logic [2*PIXEL_BITS-1:0]           ls_rd_data;
  logic signed [PIXEL_BITS-1:0]      ls_top, ls_mid;

  // Window and products
  logic signed [PIXEL_BITS-1:0]      win      [K][K];
  logic signed [PIXEL_BITS-1:0]      win_next [K][K];
  logic signed [PROD_W-1:0]          prod_next [K*K];

  // Stage 2: products
  logic                              s2_valid;
  logic signed [PROD_W-1:0]          prod [K*K];
  logic                              s2_plane_end, s2_image_end;

  // Stage 3: sum
  logic                              s3_valid;
  logic signed [SUM_W-1:0]           s3_sum;
  logic signed [SUM_W-1:0]           sum_next;
  logic                              s3_plane_end, s3_image_end;

  // Rounding and saturation
  logic signed [SUM_W:0]             rnd;
  logic signed [WIDE_W-1:0]          shf;
  logic signed [cv3_pkg::OUT_BITS-1:0] sat;

  // Flow control
  logic out_free, s3_free, s2_free, s1_leave, s1_free, pixel_xfer;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_row[0]  <= cv3_pkg::RST_COEF_ROW0;
      coef_row[1]  <= cv3_pkg::RST_COEF_ROW1;
      coef_row[2]  <= cv3_pkg::RST_COEF_ROW2;
      image_width  <= cv3_pkg::RST_WIDTH;
      image_height <= cv3_pkg::RST_HEIGHT;
      plane_count  <= cv3_pkg::RST_PCOUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cv3_pkg::REG_COEF_ROW0:    coef_row[0]  <= cfg_data;
        cv3_pkg::REG_COEF_ROW1:    coef_row[1]  <= cfg_data;
        cv3_pkg::REG_COEF_ROW2:    coef_row[2]  <= cfg_data;
        cv3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[cv3_pkg::WIDTH_BITS-1:0];
        cv3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[cv3_pkg::HEIGHT_BITS-1:0];
        cv3_pkg::REG_PLANE_COUNT:  plane_count  <= cfg_data[cv3_pkg::PCOUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp limits to their legal ranges
  always_comb begin
    if (image_width < cv3_pkg::WIDTH_BITS'(3)) begin
      w_last = COL_W'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(image_width - cv3_pkg::WIDTH_BITS'(1));
    end
    if (image_height < cv3_pkg::HEIGHT_BITS'(3)) begin
      h_last = cv3_pkg::HEIGHT_BITS'(2);
    end else begin
      h_last = image_height - cv3_pkg::HEIGHT_BITS'(1);
    end
    if (plane_count == '0) begin
      pc_last = '0;
    end else if (plane_count > cv3_pkg::PCOUNT_BITS'(4)) begin
      pc_last = cv3_pkg::PLANE_BITS'(3);
    end else begin
      pc_last = cv3_pkg::PLANE_BITS'(plane_count - cv3_pkg::PCOUNT_BITS'(1));
    end
  end

  // Position decode for the incoming pixel
  assign row_end   = column_count >= w_last;
  assign plane_end = row_end && (row_count >= h_last);
  assign image_end = plane_end && (plane_index >= pc_last);
  assign emit      = (row_count >= cv3_pkg::HEIGHT_BITS'(2)) && (column_count >= COL_W'(2));

  // Ready chain; bubbles collapse, non-emitting pixels skip stages 2..4
  assign out_free    = !result_valid || result_ready;
  assign s3_free     = !s3_valid || out_free;
  assign s2_free     = !s2_valid || s3_free;
  assign s1_leave    = s1_valid && (!s1_emit || s2_free);
  assign s1_free     = !s1_valid || s1_leave;
  assign pixel_ready = s1_free;
  assign pixel_xfer  = pixel_valid && pixel_ready;

  // Counters advance on each pixel transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      plane_index  <= '0;
    end else if (pixel_xfer) begin
      if (!row_end) begin
        column_count <= column_count + COL_W'(1);
      end else begin
        column_count <= '0;
        if (!plane_end) begin
          row_count <= row_count + cv3_pkg::HEIGHT_BITS'(1);
        end else begin
          row_count   <= '0;
          plane_index <= image_end ? '0 : plane_index + cv3_pkg::PLANE_BITS'(1);
        end
      end
    end
  end

  // Line store: {row r-2, row r-1} per column
  cv3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_leave),
    .wr_addr (s1_col),
    .wr_data ({ls_mid, s1_pixel}),
    .rd_en   (pixel_xfer),
    .rd_addr (column_count),
    .rd_data (ls_rd_data)
  );

  assign ls_top = ls_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign ls_mid = ls_rd_data[PIXEL_BITS-1:0];

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pixel_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_xfer) begin
      s1_pixel     <= pixel;
      s1_col       <= column_count;
      s1_emit      <= emit;
      s1_plane_end <= plane_end;
      s1_image_end <= image_end;
    end
  end

  // Window shift: new column enters on the right
  always_comb begin
    for (int i = 0; i < K; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = ls_top;
    win_next[1][2] = ls_mid;
    win_next[2][2] = s1_pixel;
  end

  // Nine parallel products from the shifted window
  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        prod_next[i*K+j] = win_next[i][j] * $signed(coef_row[i][CB*j +: CB]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      win <= win_next;
    end
  end

  // Stage 2 register: products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_leave && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_leave && s1_emit) begin
      prod         <= prod_next;
      s2_plane_end <= s1_plane_end;
      s2_image_end <= s1_image_end;
    end
  end

  // Sum of the nine products
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < K*K; k++) begin
      sum_next = sum_next + SUM_W'(prod[k]);
    end
  end

  // Stage 3 register: sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      s3_sum       <= sum_next;
      s3_plane_end <= s2_plane_end;
      s3_image_end <= s2_image_end;
    end
  end

  // Round half up, floor shift to Q.8, saturate to 24 bits
  always_comb begin
    rnd = (SUM_W+1)'(s3_sum) + (SUM_W+1)'(cv3_pkg::ROUND_BIAS);
    shf = WIDE_W'(rnd >>> cv3_pkg::FRAC_DROP);
    if (shf > SAT_MAX) begin
      sat = cv3_pkg::OUT_BITS'(cv3_pkg::OUT_MAX);
    end else if (shf < SAT_MIN) begin
      sat = cv3_pkg::OUT_BITS'(cv3_pkg::OUT_MIN);
    end else begin
      sat = shf[cv3_pkg::OUT_BITS-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s3_valid) begin
      out_value     <= sat;
      last_in_plane <= s3_plane_end;
      last_in_image <= s3_image_end;
    end
  end

  // Checks
  a_image_implies_plane: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_in_image |-> last_in_plane)
    else $error("last_in_image without last_in_plane");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    column_count <= COL_W'(MAX_WIDTH - 1))
    else $error("column counter beyond line store depth");

  a_xfer_fills_s1: assert property (@(posedge clk) disable iff (rst)
    pixel_xfer |=> s1_valid)
    else $error("pixel transfer lost before stage one");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    s1_leave && pixel_xfer |-> s1_col != column_count)
    else $error("line store read and write hit the same column");

endmodule
